>>> design/twpc_pkg.sv
// twpc_pkg: shared types, constants and helper functions for the
// threshold-weighted profile centroid block. No dependencies.
`default_nettype none
package twpc_pkg;

  // Scan and trig constants
  localparam int MAX_CELLS  = 4096;
  localparam int TRIG_FRAC  = 15;
  localparam int TRIG_W     = TRIG_FRAC + 1;
  localparam int QTR        = 5760;
  localparam int FULL_TURN  = 23040;
  localparam int ANG_IW     = 13;

  // Field and accumulator widths
  localparam int W_W    = 16;
  localparam int CNT_W  = 13;
  localparam int SW_W   = 28;
  localparam int WGS_W  = 45;
  localparam int WHS_W  = 47;
  localparam int H_W    = 18;
  localparam int NUM_W  = 47;
  localparam int DEN_W  = 28;
  localparam int DIVC_W = 6;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 168;
  localparam int CFG_IW = 8;
  localparam int CFG_DW = 18;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_IW-1:0] REG_DEV_HEIGHT = 8'd1;
  localparam logic [CFG_IW-1:0] REG_AZIMUTH = 8'd2;
  localparam logic [CFG_IW-1:0] REG_LOFT_LIMIT = 8'd3;

  // Q30 series constants
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef enum logic [4:0] {
    S_IDLE, S_EL_SIN, S_EL_COS, S_PROD, S_SHIFT, S_MUL, S_ACC,
    S_FIN, S_CG_GO, S_CG_WAIT, S_CH_GO, S_CH_WAIT, S_MN_GO, S_MN_WAIT,
    S_AZ_SIN, S_AZ_COS, S_AZ_END, S_EMIT
  } state_t;

  typedef enum logic [1:0] {ROM_EL_SIN, ROM_EL_COS, ROM_AZ_SIN, ROM_AZ_COS} rom_sel_t;
  typedef enum logic [1:0] {DIV_CG, DIV_CH, DIV_MEAN} div_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     capture;
    rom_sel_t rom_sel;
    logic     load_sin;
    logic     load_cos;
    logic     calc_sh;
    logic     mult;
    logic     accum;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_cg;
    logic     cap_ch;
    logic     cap_mean;
    logic     load_east;
    logic     load_north;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic empty;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [ANG_IW-1:0] idx;
    logic              neg;
  } trig_idx_t;

  // Quarter-wave sine of r (1/64 degree) in Q1.TRIG_FRAC, odd series to x^11
  function automatic logic [TRIG_W-1:0] sin_q(input logic [ANG_IW-1:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = ({51'd0, r} * PI_Q30 + 64'd5760) / 64'd11520;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    t  = (x * t) >> 30;
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    t = (t + (64'd1 << (30 - TRIG_FRAC - 1))) >> (30 - TRIG_FRAC);
    return t[TRIG_W-1:0];
  endfunction

  // Map an angle in 0..FULL_TURN-1 to a quarter-table index and sign
  function automatic trig_idx_t trig_index(input logic [14:0] a);
    trig_idx_t  res;
    logic [14:0] r;
    priority if (a < 15'(QTR)) begin
      r = a;
      res.idx = r[ANG_IW-1:0];
      res.neg = 1'b0;
    end else if (a < 15'(2 * QTR)) begin
      r = a - 15'(QTR);
      res.idx = ANG_IW'(15'(QTR) - r);
      res.neg = 1'b0;
    end else if (a < 15'(3 * QTR)) begin
      r = a - 15'(2 * QTR);
      res.idx = r[ANG_IW-1:0];
      res.neg = 1'b1;
    end else begin
      r = a - 15'(3 * QTR);
      res.idx = ANG_IW'(15'(QTR) - r);
      res.neg = 1'b1;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/threshold_weighted_profile_centroid.sv
// threshold_weighted_profile_centroid: top level joining controller,
// datapath, divider and sine table. Depends on twpc_pkg and all twpc_* modules.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata: pm25_value, slant_range, elevation; tlast: last_cell
//  out_    | master    | tdata: scan summary; tuser: none_hot
//  cfg_    | write     | cfg_index selects register, cfg_data value
//
// A cell runs two table reads of the single sine table port,
// then product, shift, weight multiply and accumulate stages.
// A last cell adds three divisions in the shared bit-serial divider, then
// the scan check, azimuth split and emit; an empty scan skips the
// divider and the split.
// Reset is synchronous, active low. Input stays open while a result waits;
// an end of scan holds in the emit step until the output register is free.
`default_nettype none
module threshold_weighted_profile_centroid (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [17:0]   cfg_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // [15:0] pm25_value, [31:16] slant_range, [45:32] elevation, [47:46] zero
  input  wire logic [47:0]   in_tdata,
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // [12:0] hot_count, [30:13] layer_bottom, [48:31] layer_top,
  // [66:49] thickness, [82:67] centroid_ground, [100:83] centroid_height,
  // [117:101] centroid_east, [134:118] centroid_north, [150:135] peak_value,
  // [166:151] mean_value, [167] spray_aloft
  output logic [167:0]       out_tdata,
  // [0] none_hot
  output logic               out_tuser
);
  import twpc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [ANG_IW-1:0] rom_addr;
  logic [TRIG_W-1:0] rom_q;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  div_quo;
  logic              div_done;

  twpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  twpc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .rom_addr   (rom_addr),
    .rom_q      (rom_q),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_quo    (div_quo),
    .div_done   (div_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  twpc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (div_num),
    .den    (div_den),
    .quo_r  (div_quo),
    .done_r (div_done)
  );

  twpc_rom u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_q)
  );

  assign in_tready = cmd.in_ready;
endmodule
`default_nettype wire

>>> design/twpc_rom.sv
// twpc_rom: quarter-wave sine table, 5761 entries, registered read.
// Depends on twpc_pkg (sin_q, table constants).
`default_nettype none
module twpc_rom (
  input  wire logic                          clk,
  input  wire logic [twpc_pkg::ANG_IW-1:0]   addr,
  output logic      [twpc_pkg::TRIG_W-1:0]   data_r
);
  import twpc_pkg::*;

  logic [TRIG_W-1:0] tbl [0:QTR];

  // Build table entries at elaboration
  for (genvar g = 0; g <= QTR; g++) begin : g_tbl
    localparam logic [TRIG_W-1:0] V = sin_q(ANG_IW'(g));
    assign tbl[g] = V;
  end

  // Registered read
  always_ff @(posedge clk) begin
    data_r <= tbl[addr];
  end
endmodule
`default_nettype wire

>>> design/twpc_div.sv
// twpc_div: restoring divider, one quotient bit per cycle.
// Depends on twpc_pkg (widths).
`default_nettype none
module twpc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [twpc_pkg::NUM_W-1:0]  num,
  input  wire logic [twpc_pkg::DEN_W-1:0]  den,
  output logic      [twpc_pkg::NUM_W-1:0]  quo_r,
  output logic                             done_r
);
  import twpc_pkg::*;

  logic [DIVC_W-1:0] cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]  quo_nxt;

  // Trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = ~diff[DEN_W+1];
    rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  // Iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIVC_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVC_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/twpc_ctrl.sv
// twpc_ctrl: sequencer for cell accumulation and the end-of-scan result.
// Depends on twpc_pkg (state_t, cmd_t, sts_t).
`default_nettype none
module twpc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire twpc_pkg::sts_t sts,
  output twpc_pkg::cmd_t      cmd
);
  import twpc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_EL_SIN;
      S_EL_SIN:  state_nxt = S_EL_COS;
      S_EL_COS:  state_nxt = S_PROD;
      S_PROD:    state_nxt = S_SHIFT;
      S_SHIFT:   state_nxt = S_MUL;
      S_MUL:     state_nxt = S_ACC;
      S_ACC:     state_nxt = sts.last ? S_FIN : S_IDLE;
      S_FIN:     state_nxt = sts.empty ? S_EMIT : S_CG_GO;
      S_CG_GO:   state_nxt = S_CG_WAIT;
      S_CG_WAIT: if (sts.div_done) state_nxt = S_CH_GO;
      S_CH_GO:   state_nxt = S_CH_WAIT;
      S_CH_WAIT: if (sts.div_done) state_nxt = S_MN_GO;
      S_MN_GO:   state_nxt = S_MN_WAIT;
      S_MN_WAIT: if (sts.div_done) state_nxt = S_AZ_SIN;
      S_AZ_SIN:  state_nxt = S_AZ_COS;
      S_AZ_COS:  state_nxt = S_AZ_END;
      S_AZ_END:  state_nxt = S_EMIT;
      S_EMIT:    if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.rom_sel = ROM_EL_SIN;
    cmd.div_sel = DIV_CG;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_tvalid;
      end
      S_EL_SIN:  cmd.rom_sel = ROM_EL_SIN;
      S_EL_COS: begin
        cmd.rom_sel  = ROM_EL_COS;
        cmd.load_sin = 1'b1;
      end
      S_PROD:    cmd.load_cos = 1'b1;
      S_SHIFT:   cmd.calc_sh = 1'b1;
      S_MUL:     cmd.mult = 1'b1;
      S_ACC:     cmd.accum = 1'b1;
      S_CG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CG;
      end
      S_CG_WAIT: cmd.cap_cg = sts.div_done;
      S_CH_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CH;
      end
      S_CH_WAIT: cmd.cap_ch = sts.div_done;
      S_MN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
      end
      S_MN_WAIT: cmd.cap_mean = sts.div_done;
      S_AZ_SIN:  cmd.rom_sel = ROM_AZ_SIN;
      S_AZ_COS: begin
        cmd.rom_sel   = ROM_AZ_COS;
        cmd.load_east = 1'b1;
      end
      S_AZ_END:  cmd.load_north = 1'b1;
      S_EMIT:    cmd.emit = sts.out_free;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> design/twpc_dp.sv
// twpc_dp: datapath with config registers, cell mapping, accumulators,
// result assembly and output register. Depends on twpc_pkg.
`default_nettype none
module twpc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [twpc_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [twpc_pkg::CFG_DW-1:0]   cfg_data,
  input  wire logic [twpc_pkg::IN_W-1:0]     in_tdata,
  input  wire logic                          in_tlast,
  input  wire twpc_pkg::cmd_t                cmd,
  output twpc_pkg::sts_t                     sts,
  output logic      [twpc_pkg::ANG_IW-1:0]   rom_addr,
  input  wire logic [twpc_pkg::TRIG_W-1:0]   rom_q,
  output logic      [twpc_pkg::NUM_W-1:0]    div_num,
  output logic      [twpc_pkg::DEN_W-1:0]    div_den,
  input  wire logic [twpc_pkg::NUM_W-1:0]    div_quo,
  input  wire logic                          div_done,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [twpc_pkg::OUT_W-1:0]    out_tdata,
  output logic                               out_tuser
);
  import twpc_pkg::*;

  localparam int PW = 2 * W_W;

  // Configuration
  logic [W_W-1:0]        thr_r;
  logic [W_W-1:0]        dev_r;
  logic [14:0]           az_r;
  logic signed [H_W-1:0] lim_r;

  // Cell registers
  logic [W_W-1:0]        w_r;
  logic [W_W-1:0]        rng_r;
  logic [ANG_IW-1:0]     el_mag_r;
  logic                  el_neg_r;
  logic                  last_r;
  logic [PW-1:0]         psin_r;
  logic [PW-1:0]         pcos_r;
  logic [W_W-1:0]        s_r;
  logic signed [H_W-1:0] h_r;
  logic [PW-1:0]         ws_r;
  logic signed [34:0]    wh_r;

  // Accumulators
  logic [CNT_W-1:0]        cnt_r;
  logic [SW_W-1:0]         sw_r;
  logic [WGS_W-1:0]        wgs_r;
  logic signed [WHS_W-1:0] whs_r;
  logic signed [H_W-1:0]   lo_r;
  logic signed [H_W-1:0]   hi_r;
  logic [W_W-1:0]          peak_r;

  // Result registers
  logic [W_W-1:0]        cg_r;
  logic signed [H_W-1:0] ch_r;
  logic [W_W-1:0]        mean_r;
  logic [16:0]           east_r;
  logic [16:0]           north_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;
  logic                  out_none_r;

  logic signed [13:0]    el_in;
  logic [ANG_IW-1:0]     el_mag_nxt;
  logic                  el_neg_nxt;
  logic signed [PW:0]    hs_prod;
  logic signed [PW:0]    hs_shift;
  logic [14:0]           az_m;
  logic [15:0]           az_c_sum;
  logic [14:0]           az_c;
  trig_idx_t             az_sin;
  trig_idx_t             az_cos;
  logic [PW-1:0]         pe;
  logic signed [PW:0]    pe_signed;
  logic signed [PW:0]    pe_shift;
  logic                  hot;
  logic                  empty;
  logic [WHS_W-1:0]      whs_mag;
  logic [OUT_W-1:0]      pack;
  logic                  spray;
  logic [H_W-1:0]        thick;

  // Write config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd960;
      dev_r <= 16'd288;
      az_r  <= 15'd2560;
      lim_r <= 18'sd560;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr_r <= cfg_data[W_W-1:0];
        REG_DEV_HEIGHT: dev_r <= cfg_data[W_W-1:0];
        REG_AZIMUTH:    az_r  <= cfg_data[14:0];
        REG_LOFT_LIMIT: lim_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Saturate elevation to +-90 degrees, split sign and magnitude
  always_comb begin
    el_in = $signed(in_tdata[45:32]);
    if (el_in > 14'sd5760) begin
      el_mag_nxt = ANG_IW'(QTR);
      el_neg_nxt = 1'b0;
    end else if (el_in < -14'sd5760) begin
      el_mag_nxt = ANG_IW'(QTR);
      el_neg_nxt = 1'b1;
    end else if (el_in < 14'sd0) begin
      el_mag_nxt = ANG_IW'(-el_in);
      el_neg_nxt = 1'b1;
    end else begin
      el_mag_nxt = el_in[ANG_IW-1:0];
      el_neg_nxt = 1'b0;
    end
  end

  // Azimuth indexes for sine and cosine
  always_comb begin
    az_m     = (az_r >= 15'(FULL_TURN)) ? az_r - 15'(FULL_TURN) : az_r;
    az_c_sum = {1'b0, az_m} + 16'(QTR);
    az_c     = (az_c_sum >= 16'(FULL_TURN)) ? 15'(az_c_sum - 16'(FULL_TURN)) :
                                              az_c_sum[14:0];
    az_sin   = trig_index(az_m);
    az_cos   = trig_index(az_c);
  end

  // Select table address
  always_comb begin
    unique case (cmd.rom_sel)
      ROM_EL_SIN: rom_addr = el_mag_r;
      ROM_EL_COS: rom_addr = ANG_IW'(QTR) - el_mag_r;
      ROM_AZ_SIN: rom_addr = az_sin.idx;
      ROM_AZ_COS: rom_addr = az_cos.idx;
      default:    rom_addr = el_mag_r;
    endcase
  end

  // Height offset floor and centroid split products
  always_comb begin
    hs_prod   = el_neg_r ? -$signed({1'b0, psin_r}) : $signed({1'b0, psin_r});
    hs_shift  = hs_prod >>> TRIG_FRAC;
    pe        = {16'd0, cg_r} * {16'd0, rom_q};
    pe_signed = (cmd.load_east ? az_sin.neg : az_cos.neg) ? -$signed({1'b0, pe}) :
                                                             $signed({1'b0, pe});
    pe_shift  = pe_signed >>> TRIG_FRAC;
  end

  assign hot   = (w_r > thr_r) && (cnt_r < CNT_W'(MAX_CELLS));
  assign empty = (cnt_r == '0) || (sw_r == '0);

  // Capture the beat and run the per-cell mapping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_r      <= in_tdata[15:0];
      rng_r    <= in_tdata[31:16];
      el_mag_r <= el_mag_nxt;
      el_neg_r <= el_neg_nxt;
      last_r   <= in_tlast;
    end
    if (cmd.load_sin) begin
      psin_r <= {16'd0, rng_r} * {16'd0, rom_q};
    end
    if (cmd.load_cos) begin
      pcos_r <= {16'd0, rng_r} * {16'd0, rom_q};
    end
    if (cmd.calc_sh) begin
      s_r <= pcos_r[TRIG_FRAC+W_W-1:TRIG_FRAC];
      h_r <= $signed(hs_shift[H_W-1:0]) + $signed({2'b00, dev_r});
    end
    if (cmd.mult) begin
      ws_r <= {16'd0, w_r} * {16'd0, s_r};
      wh_r <= 35'($signed({1'b0, w_r}) * h_r);
    end
  end

  // Accumulate hot cells; clear on reset and when the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      cnt_r  <= '0;
      sw_r   <= '0;
      wgs_r  <= '0;
      whs_r  <= '0;
      lo_r   <= 18'sd131071;
      hi_r   <= 18'sh20000;
      peak_r <= '0;
    end else if (cmd.accum && hot) begin
      cnt_r <= cnt_r + 1'b1;
      sw_r  <= sw_r + SW_W'(w_r);
      wgs_r <= wgs_r + WGS_W'(ws_r);
      whs_r <= whs_r + WHS_W'(wh_r);
      if (h_r < lo_r) lo_r <= h_r;
      if (h_r > hi_r) hi_r <= h_r;
      if (w_r > peak_r) peak_r <= w_r;
    end
  end

  // Divider operands
  assign whs_mag = whs_r[WHS_W-1] ? WHS_W'(-whs_r) : WHS_W'(whs_r);
  always_comb begin
    unique case (cmd.div_sel)
      DIV_CG: begin
        div_num = NUM_W'(wgs_r);
        div_den = sw_r;
      end
      DIV_CH: begin
        div_num = whs_mag;
        div_den = sw_r;
      end
      DIV_MEAN: begin
        div_num = NUM_W'(sw_r);
        div_den = DEN_W'(cnt_r);
      end
      default: begin
        div_num = NUM_W'(wgs_r);
        div_den = sw_r;
      end
    endcase
  end

  // Capture quotients and azimuth split
  always_ff @(posedge clk) begin
    if (cmd.cap_cg) cg_r <= div_quo[W_W-1:0];
    if (cmd.cap_ch) begin
      ch_r <= whs_r[WHS_W-1] ? -$signed(div_quo[H_W-1:0]) : $signed(div_quo[H_W-1:0]);
    end
    if (cmd.cap_mean) mean_r <= div_quo[W_W-1:0];
    if (cmd.load_east) east_r <= pe_shift[16:0];
    if (cmd.load_north) north_r <= pe_shift[16:0];
  end

  // Assemble the result beat
  always_comb begin
    spray = ch_r > lim_r;
    thick = H_W'(hi_r - lo_r);
    pack  = {spray, mean_r, peak_r, north_r, east_r, ch_r, cg_r, thick,
             hi_r, lo_r, cnt_r};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= empty ? '0 : pack;
      out_none_r <= empty;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_none_r;
  assign sts.last     = last_r;
  assign sts.empty    = empty;
  assign sts.div_done = div_done;
  assign sts.out_free = ~out_valid_r | out_tready;
endmodule
`default_nettype wire

>>> sim/tb_threshold_weighted_profile_centroid.sv
// Testbench for threshold_weighted_profile_centroid: streams scan cells, predicts
// each scan summary with a behavioral profile model, and checks every result beat.
// Depends on twpc_pkg and the RTL of the block.
`default_nettype none
module tb_threshold_weighted_profile_centroid;
  timeunit 1ns;
  timeprecision 1ps;
  import twpc_pkg::*;

  typedef struct packed {
    logic [12:0] hot_count;
    logic        none_hot;
    logic [17:0] layer_bottom;
    logic [17:0] layer_top;
    logic [17:0] thickness;
    logic [15:0] centroid_ground;
    logic [17:0] centroid_height;
    logic [16:0] centroid_east;
    logic [16:0] centroid_north;
    logic [15:0] peak_value;
    logic [15:0] mean_value;
    logic        spray_aloft;
  } summary_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [7:0]   cfg_index;
  logic [17:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;
  logic         out_tuser;

  // Predictor copy of configuration and scan accumulators
  longint unsigned thr_q, dev_h_q, az_q;
  longint          loft_q;
  longint          n_hot, w_sum, wg_sum, wh_sum, low_h, high_h, peak_w;

  summary_t summary_q[$];
  int       errors;
  int       idle_cycles;
  bit       hold_off;

  threshold_weighted_profile_centroid dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Quarter-wave sine in Q30, odd series to x^11
  function automatic longint unsigned quarter_sine(longint unsigned r);
    longint unsigned x, x2, t;
    x  = (r * 64'd3373259426 + 64'd5760) / 64'd11520;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    if (t > 64'd1073741824) t = 64'd1073741824;
    return t;
  endfunction

  function automatic longint sine_q15(longint unsigned a);
    longint unsigned q, r, v;
    q = a / QTR;
    r = a % QTR;
    v = quarter_sine(q[0] ? QTR - r : r);
    v = (v + (64'd1 << 14)) >> 15;
    return (q >= 2) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint cosine_q15(longint unsigned a);
    return sine_q15((a + QTR) % FULL_TURN);
  endfunction

  function automatic longint floor_q15(longint v);
    return v >>> 15;
  endfunction

  function automatic void clear_profile();
    n_hot = 0; w_sum = 0; wg_sum = 0; wh_sum = 0;
    low_h = 131071; high_h = -131072; peak_w = 0;
  endfunction

  function automatic void apply_register(logic [7:0] idx, logic [17:0] val);
    unique case (idx)
      REG_THRESHOLD:  thr_q = val[15:0];
      REG_DEV_HEIGHT: dev_h_q = val[15:0];
      REG_AZIMUTH:    az_q = val[14:0];
      REG_LOFT_LIMIT: loft_q = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // Fold one cell into the profile; return 1 with the summary on the last cell
  function automatic bit profile_cell(logic [15:0] w, logic [15:0] rng, logic [13:0] el_raw,
                                      logic last, output summary_t sm);
    longint el, s, h, cg, ch;
    longint unsigned a, az;
    el = longint'($signed(el_raw));
    if (el > QTR) el = QTR;
    if (el < -QTR) el = -QTR;
    if (w > thr_q && n_hot < MAX_CELLS) begin
      a = (el < 0) ? el + FULL_TURN : el;
      s = floor_q15(longint'(rng) * cosine_q15(a));
      h = longint'(dev_h_q) + floor_q15(longint'(rng) * sine_q15(a));
      n_hot++;
      w_sum += w;
      wg_sum += longint'(w) * s;
      wh_sum += longint'(w) * h;
      if (h < low_h) low_h = h;
      if (h > high_h) high_h = h;
      if (w > peak_w) peak_w = w;
    end
    sm = '0;
    if (!last) return 1'b0;
    if (n_hot == 0 || w_sum == 0) begin
      sm.none_hot = 1'b1;
    end else begin
      cg = wg_sum / w_sum;
      ch = wh_sum / w_sum;
      az = az_q % FULL_TURN;
      sm.hot_count       = n_hot[12:0];
      sm.layer_bottom    = low_h[17:0];
      sm.layer_top       = high_h[17:0];
      sm.thickness       = 18'(high_h - low_h);
      sm.centroid_ground = cg[15:0];
      sm.centroid_height = ch[17:0];
      sm.centroid_east   = 17'(floor_q15(cg * sine_q15(az)));
      sm.centroid_north  = 17'(floor_q15(cg * cosine_q15(az)));
      sm.peak_value      = peak_w[15:0];
      sm.mean_value      = 16'(w_sum / n_hot);
      sm.spray_aloft     = ch > loft_q;
    end
    clear_profile();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string field, longint got, longint exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, exp, $realtime);
    errors++;
  endtask

  // Send one cell beat, with a random gap before it
  task automatic send_cell(logic [15:0] w, logic [15:0] rng, logic [13:0] el, logic last);
    summary_t sm;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, el, rng, w};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (profile_cell(w, rng, el, last, sm)) summary_q = {summary_q, sm};
    @(negedge clk);
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    end_stream();
    while (summary_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Hold the write for one cycle, then go idle before the next
  task automatic write_register(logic [7:0] idx, logic [17:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    apply_register(idx, val);
  endtask

  function automatic logic [13:0] random_elevation();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 14'($urandom);
    return 14'($signed($urandom_range(0, 11520)) - 5760);
  endfunction

  task automatic send_scan(int cells);
    for (int i = 0; i < cells; i++)
      send_cell(16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000)),
                16'($urandom), random_elevation(), i == cells - 1);
  endtask

  // Extremes of every field and each special case
  task automatic test_directed();
    send_cell(16'hFFFF, 16'hFFFF, 14'(5760), 1'b1);
    send_cell(16'hFFFF, 16'hFFFF, 14'(-5760), 1'b1);
    send_cell(16'h0000, 16'h0000, 14'h0000, 1'b1);            // empty scan
    send_cell(16'd961, 16'h0000, 14'h1FFF, 1'b0);              // saturate up
    send_cell(16'd960, 16'h1234, 14'h2000, 1'b0);              // at threshold
    send_cell(16'd5000, 16'h8000, 14'h2000, 1'b1);             // saturate down
    send_cell(16'd4000, 16'd3000, 14'(1000), 1'b0);
    send_cell(16'd100, 16'd3000, 14'(1000), 1'b1);             // last not hot
    send_cell(16'd3000, 16'd0, 14'(-2880), 1'b0);
    send_cell(16'hFFFF, 16'h5555, 14'h2AAA, 1'b0);
    send_cell(16'h8000, 16'hAAAA, 14'h1555, 1'b1);
    drain();
  endtask

  // Walk through register settings, extremes included
  task automatic test_registers();
    logic [17:0] thr[4], dh[4], az[5], lim[4];
    thr = '{18'd0, 18'hFFFF, 18'd1000, 18'd30000};
    dh  = '{18'd0, 18'hFFFF, 18'd500, 18'd288};
    az  = '{18'd0, 18'd23039, 18'h7FFF, 18'd11520, 18'd17000};
    lim = '{18'h20000, 18'h1FFFF, 18'd0, 18'h3FF00};
    for (int p = 0; p < 5; p++) begin
      write_register(REG_THRESHOLD, thr[p % 4]);
      write_register(REG_DEV_HEIGHT, dh[p % 4]);
      write_register(REG_AZIMUTH, az[p]);
      write_register(REG_LOFT_LIMIT, lim[p % 4]);
      write_register(8'hFF, 18'h3FFFF);                     // unused index
      send_scan(3);
      send_scan(1);
      drain();
    end
    write_register(REG_THRESHOLD, 18'd960);
  endtask

  // Random scans under random registers
  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 690) begin
      if ($urandom_range(0, 4) == 0) begin
        write_register(REG_THRESHOLD, 18'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000)));
        write_register(REG_DEV_HEIGHT, 18'($urandom));
        write_register(REG_AZIMUTH, 18'($urandom));
        write_register(REG_LOFT_LIMIT, 18'($urandom));
      end
      for (int s = 0; s < 6; s++) begin
        int n;
        n = $urandom_range(1, 12);
        send_scan(n);
        sent += n;
      end
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while cells keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_scan(3);
    drain();
  endtask

  // Drive out_tready: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    end
  end

  // Check each result beat against the oldest expected summary
  always @(posedge clk) begin
    summary_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[12:0], out_tuser, out_tdata[30:13], out_tdata[48:31],
              out_tdata[66:49], out_tdata[82:67], out_tdata[100:83],
              out_tdata[117:101], out_tdata[134:118], out_tdata[150:135],
              out_tdata[166:151], out_tdata[167]};
      if (summary_q.size() == 0) begin
        report_mismatch("unexpected result", got.hot_count, 0);
      end else begin
        exp = summary_q.pop_front();
        if (got.hot_count != exp.hot_count)
          report_mismatch("hot_count", got.hot_count, exp.hot_count);
        if (got.none_hot != exp.none_hot)
          report_mismatch("none_hot", got.none_hot, exp.none_hot);
        if (got.layer_bottom != exp.layer_bottom)
          report_mismatch("layer_bottom", got.layer_bottom, exp.layer_bottom);
        if (got.layer_top != exp.layer_top)
          report_mismatch("layer_top", got.layer_top, exp.layer_top);
        if (got.thickness != exp.thickness)
          report_mismatch("thickness", got.thickness, exp.thickness);
        if (got.centroid_ground != exp.centroid_ground)
          report_mismatch("centroid_ground", got.centroid_ground, exp.centroid_ground);
        if (got.centroid_height != exp.centroid_height)
          report_mismatch("centroid_height", got.centroid_height, exp.centroid_height);
        if (got.centroid_east != exp.centroid_east)
          report_mismatch("centroid_east", got.centroid_east, exp.centroid_east);
        if (got.centroid_north != exp.centroid_north)
          report_mismatch("centroid_north", got.centroid_north, exp.centroid_north);
        if (got.peak_value != exp.peak_value)
          report_mismatch("peak_value", got.peak_value, exp.peak_value);
        if (got.mean_value != exp.mean_value)
          report_mismatch("mean_value", got.mean_value, exp.mean_value);
        if (got.spray_aloft != exp.spray_aloft)
          report_mismatch("spray_aloft", got.spray_aloft, exp.spray_aloft);
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; hold_off = 1'b0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0; out_tready = 1'b0;
    thr_q = 960; dev_h_q = 288; az_q = 2560; loft_q = 560;
    clear_profile();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
